// ===== hw/rtl/fisc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame id sequence checker package
// Shared constants, verdict codes and types of the sequence checker.
// ----------------------------------------------------------------------------
package fisc_pkg;

    // Number of tracked streams; higher stream numbers are unknown.
    localparam int NUM_STREAMS = 3;

    localparam int STREAM_W  = 2;
    localparam int ID_W      = 32;
    localparam int GAP_W     = 31;
    localparam int COUNT_W   = 32;
    localparam int VERDICT_W = 3;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_FIRST     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_IN_ORDER  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_REORDER   = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN   = 3'd4;

    // Per-stream tracking state.
    typedef struct packed {
        logic               seen;
        logic [ID_W-1:0]    last_id;
        logic [COUNT_W-1:0] dup_count;
        logic [COUNT_W-1:0] reo_count;
        logic [COUNT_W-1:0] lost_count;
    } stream_entry_t;

    // One result beat.
    typedef struct packed {
        logic                 accept;
        logic [VERDICT_W-1:0] verdict;
        logic [GAP_W-1:0]     gap;
        logic [COUNT_W-1:0]   duplicate_total;
        logic [COUNT_W-1:0]   reorder_total;
        logic [COUNT_W-1:0]   lost_total;
    } result_t;

    // Write-back request from the check logic to the stream state.
    typedef struct packed {
        logic                wr_en;
        logic [STREAM_W-1:0] wr_index;
        stream_entry_t       wr_entry;
    } state_update_t;

endpackage

// ===== hw/rtl/frame_id_sequence_checker_core.sv =====
// ----------------------------------------------------------------------------
// Frame id sequence checker
// An input beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless out_ready stalls; the check is a
// single read-modify-write of the stream state between the two registers.
// Reset clears all stream state (seen flags, last ids, counters) at once.
// ----------------------------------------------------------------------------
module frame_id_sequence_checker_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fisc_pkg::STREAM_W-1:0]     stream_index,
    input  logic [fisc_pkg::ID_W-1:0]         frame_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accept,
    output logic [fisc_pkg::VERDICT_W-1:0]    verdict,
    output logic [fisc_pkg::GAP_W-1:0]        gap,
    output logic [fisc_pkg::COUNT_W-1:0]      duplicate_total,
    output logic [fisc_pkg::COUNT_W-1:0]      reorder_total,
    output logic [fisc_pkg::COUNT_W-1:0]      lost_total
);
    import fisc_pkg::*;

    logic                s1_valid_reg;
    logic [STREAM_W-1:0] s1_stream_reg;
    logic [ID_W-1:0]     s1_id_reg;
    logic                out_valid_reg;
    result_t             result_reg;

    logic                advance;
    stream_entry_t       rd_entry;
    result_t             result_next;
    state_update_t       update;

    // The checked beat moves to the result register when that is free.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_stream_reg <= stream_index;
            s1_id_reg     <= frame_id;
        end
    end

    fisc_stream_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (s1_stream_reg),
        .rd_entry (rd_entry),
        .update   (update)
    );

    fisc_check u_check (
        .fire         (advance),
        .stream_index (s1_stream_reg),
        .frame_id     (s1_id_reg),
        .entry        (rd_entry),
        .result       (result_next),
        .update       (update)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign accept          = result_reg.accept;
    assign verdict         = result_reg.verdict;
    assign gap             = result_reg.gap;
    assign duplicate_total = result_reg.duplicate_total;
    assign reorder_total   = result_reg.reorder_total;
    assign lost_total      = result_reg.lost_total;

    // Accept is set exactly for first and in-order verdicts.
    a_accept_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accept == ((verdict == VERDICT_FIRST) ||
                                  (verdict == VERDICT_IN_ORDER))))
        else $error("accept does not match verdict");

    // A nonzero gap only comes with an in-order verdict.
    a_gap_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (gap != '0)) |-> (verdict == VERDICT_IN_ORDER))
        else $error("gap reported outside an in-order verdict");

    // An unknown stream reports zero totals.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == VERDICT_UNKNOWN)) |->
            ((duplicate_total == '0) && (reorder_total == '0) && (lost_total == '0)))
        else $error("unknown stream reports nonzero totals");

    // A stalled result is never overwritten by the next beat.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

// ===== hw/rtl/fisc_stream_state.sv =====
// ----------------------------------------------------------------------------
// Stream state store
// Holds seen flag, last id and the three counters of every stream, with one
// combinational read port and one write port.
// ----------------------------------------------------------------------------
module fisc_stream_state (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [fisc_pkg::STREAM_W-1:0] rd_index,
    output fisc_pkg::stream_entry_t rd_entry,
    input  fisc_pkg::state_update_t update
);
    import fisc_pkg::*;

    stream_entry_t entries_reg [NUM_STREAMS];

    // Read the addressed stream; unknown streams read as all zero.
    always_comb
    begin
        rd_entry = '0;
        if (rd_index < STREAM_W'(NUM_STREAMS))
        begin
            rd_entry = entries_reg[rd_index];
        end
    end

    // Write back the updated entry of a known stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (update.wr_en)
        begin
            entries_reg[update.wr_index] <= update.wr_entry;
        end
    end

endmodule

// ===== hw/rtl/fisc_check.sv =====
// ----------------------------------------------------------------------------
// Sequence check logic
// Compares one frame id with its stream's last accepted id using serial
// number arithmetic and forms the result and the state update.
// ----------------------------------------------------------------------------
module fisc_check (
    input  logic                        fire,
    input  logic [fisc_pkg::STREAM_W-1:0] stream_index,
    input  logic [fisc_pkg::ID_W-1:0]   frame_id,
    input  fisc_pkg::stream_entry_t     entry,
    output fisc_pkg::result_t           result,
    output fisc_pkg::state_update_t     update
);
    import fisc_pkg::*;

    logic [ID_W-1:0]    fwd_distance;
    logic [ID_W-1:0]    dist_m1;
    logic               known;
    stream_entry_t      next_entry;

    // Forward distance modulo 2^32.
    assign fwd_distance = frame_id - entry.last_id;
    assign dist_m1      = fwd_distance - ID_W'(1);
    assign known        = (stream_index < STREAM_W'(NUM_STREAMS));

    // Decide the verdict and the new stream entry.
    always_comb
    begin
        next_entry     = entry;
        result         = '0;
        result.verdict = VERDICT_UNKNOWN;
        if (known)
        begin
            if (!entry.seen)
            begin
                next_entry.seen    = 1'b1;
                next_entry.last_id = frame_id;
                result.accept      = 1'b1;
                result.verdict     = VERDICT_FIRST;
            end
            else if (fwd_distance == '0)
            begin
                next_entry.dup_count = entry.dup_count + COUNT_W'(1);
                result.verdict       = VERDICT_DUPLICATE;
            end
            else if (fwd_distance[ID_W-1])
            begin
                next_entry.reo_count = entry.reo_count + COUNT_W'(1);
                result.verdict       = VERDICT_REORDER;
            end
            else
            begin
                next_entry.lost_count = entry.lost_count + COUNT_W'(dist_m1[GAP_W-1:0]);
                next_entry.last_id    = frame_id;
                result.gap            = dist_m1[GAP_W-1:0];
                result.accept         = 1'b1;
                result.verdict        = VERDICT_IN_ORDER;
            end
            result.duplicate_total = next_entry.dup_count;
            result.reorder_total   = next_entry.reo_count;
            result.lost_total      = next_entry.lost_count;
        end
    end

    // Write back only when the beat moves on and the stream is known.
    assign update.wr_en    = fire && known;
    assign update.wr_index = stream_index;
    assign update.wr_entry = next_entry;

endmodule
